@@ src/assert_macros.svh @@
// Assertion helpers for the Bezier splat unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ src/bdcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bdcs_pkg;
    localparam int MaxPoints = 16;
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int CoordW = 18;
    localparam int TW = 17;
    localparam logic [TW-1:0] TOne = 17'h10000;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [17:0] point_x;
        logic [17:0] point_y;
        logic [16:0] t_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] intensity;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic            load;
        logic            shift;
        logic [TW-1:0]   t;
    } t_cell_ctrl;

    function automatic logic [CoordW-1:0] lerp(input logic [CoordW-1:0] a,
                                               input logic [CoordW-1:0] b,
                                               input logic [TW-1:0] t);
        logic [35:0] s;
        s = {18'd0, a} * {19'd0, TOne - t} + {18'd0, b} * {19'd0, t} + 36'd32768;
        return s[16 +: CoordW];
    endfunction
endpackage
`default_nettype wire

@@ src/bezier_de_casteljau_splat_top.sv @@
// Bezier de Casteljau splat unit.
// Input channel (i_in_valid/o_in_stall, payload i_in) carries clear, load and
// evaluate requests; output channel (o_out_valid/i_out_stall, payload o_out)
// carries nine pixel items per evaluate, the ninth with last_of_run set.
// Control points live in a row of sixteen cells. A clear or load is handled in
// S_IDLE without leaving it. An evaluate first copies the stored points into
// the working row, then runs n-1 reduction passes, in each of which every cell
// blends with its right neighbor; then S_BASE forms the base pixel, then nine
// items follow, one per cycle when the receiver does not stall.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) set frame width and
// height; both reset to 700. Reset empties the store and drops any item in
// flight. A stalled output item holds until taken; no new request is accepted
// until all nine items of an evaluate have gone.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bezier_de_casteljau_splat_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bdcs_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bdcs_pkg::t_out_item       o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [10:0]          i_cfg_data
);
    localparam int N = bdcs_pkg::MaxPoints;
    localparam int W = bdcs_pkg::CoordW;

    typedef enum logic [2:0] {S_IDLE, S_COPY, S_REDUCE, S_BASE, S_EMIT} t_state;

    t_state r_state;
    logic [10:0] r_fw, r_fh;
    logic [bdcs_pkg::CntW-1:0] r_count, r_levels;
    logic [W-1:0] r_sx [N];
    logic [W-1:0] r_sy [N];
    logic [bdcs_pkg::TW-1:0] r_t;
    logic [W-1:0] r_px, r_py;
    logic [9:0] r_bx, r_by, r_wmax, r_hmax;
    logic [1:0] r_j, r_k;
    logic r_nonempty;

    bdcs_pkg::t_cell_ctrl w_ctrl;
    logic [W-1:0] w_cx [N+1];
    logic [W-1:0] w_cy [N+1];

    assign w_cx[N] = '0;
    assign w_cy[N] = '0;
    assign w_ctrl.load = (r_state == S_COPY);
    assign w_ctrl.shift = (r_state == S_REDUCE);
    assign w_ctrl.t = r_t;

    for (genvar g = 0; g < N; g++) begin : g_cell
        bdcs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_load_x(r_sx[g]),
            .i_load_y(r_sy[g]),
            .i_next_x(w_cx[g+1]),
            .i_next_y(w_cy[g+1]),
            .o_x     (w_cx[g]),
            .o_y     (w_cy[g])
        );
    end

    assign o_in_stall = (r_state != S_IDLE);
    wire w_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 11'd700;
            r_fh <= 11'd700;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bdcs_pkg::CFG_WIDTH) r_fw <= i_cfg_data;
            else r_fh <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.req_type == bdcs_pkg::REQ_LOAD && r_count < N) begin
            r_sx[r_count[$clog2(N)-1:0]] <= i_in.point_x;
            r_sy[r_count[$clog2(N)-1:0]] <= i_in.point_y;
        end
    end

    // Offsets in order 0, -1, +1, clamped to the frame.
    function automatic logic [9:0] nb(input logic [9:0] b, input logic [1:0] o,
                                      input logic [9:0] mx);
        logic [9:0] r;
        r = b;
        case (o)
            2'd1: r = (b == 10'd0) ? 10'd0 : b - 10'd1;
            2'd2: r = (b >= mx) ? mx : b + 10'd1;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] lim(input logic [10:0] s);
        logic [9:0] r;
        if (s == 11'd0) r = 10'd0;
        else if (s > 11'd1024) r = 10'd1023;
        else r = 10'(s - 11'd1);
        return r;
    endfunction

    logic [9:0] w_nx, w_ny;
    logic [W:0] w_dx, w_dy, w_cxv, w_cyv;
    logic [W+1:0] w_d;
    logic [17:0] w_prod;
    assign w_nx = nb(r_bx, r_j, r_wmax);
    assign w_ny = nb(r_by, r_k, r_hmax);
    assign w_cxv = {1'b0, w_nx, 8'd128};
    assign w_cyv = {1'b0, w_ny, 8'd128};
    assign w_dx = ({1'b0, r_px} > w_cxv) ? {1'b0, r_px} - w_cxv : w_cxv - {1'b0, r_px};
    assign w_dy = ({1'b0, r_py} > w_cyv) ? {1'b0, r_py} - w_cyv : w_cyv - {1'b0, r_py};
    assign w_d = {1'b0, w_dx} + {1'b0, w_dy};
    assign w_prod = (10'd512 - w_d[9:0]) * 8'd255;

    logic [9:0] w_bx0, w_by0;
    assign w_bx0 = (w_cx[0][W-1:8] > r_wmax) ? r_wmax : w_cx[0][W-1:8];
    assign w_by0 = (w_cy[0][W-1:8] > r_hmax) ? r_hmax : w_cy[0][W-1:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.req_type == bdcs_pkg::REQ_CLEAR) r_count <= '0;
                        else if (i_in.req_type == bdcs_pkg::REQ_LOAD) begin
                            if (r_count < N) r_count <= r_count + 1'b1;
                        end else if (i_in.req_type == bdcs_pkg::REQ_EVAL) begin
                            r_t <= (i_in.t_value > bdcs_pkg::TOne) ? bdcs_pkg::TOne
                                                                   : i_in.t_value;
                            r_levels <= (r_count == 0) ? '0 : r_count - 1'b1;
                            r_nonempty <= (r_count != 0);
                            r_wmax <= lim(r_fw);
                            r_hmax <= lim(r_fh);
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: r_state <= (r_levels == 0) ? S_BASE : S_REDUCE;
                S_REDUCE: begin
                    r_levels <= r_levels - 1'b1;
                    if (r_levels == 1) r_state <= S_BASE;
                end
                S_BASE: begin
                    r_px <= r_nonempty ? w_cx[0] : '0;
                    r_py <= r_nonempty ? w_cy[0] : '0;
                    r_bx <= r_nonempty ? w_bx0 : '0;
                    r_by <= r_nonempty ? w_by0 : '0;
                    r_j <= 2'd0;
                    r_k <= 2'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        if (o_out_valid && o_out.last_of_run) begin
                            o_out_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (!(o_out_valid && r_j == 2'd3)) begin
                            o_out_valid <= 1'b1;
                            o_out.pixel_x <= w_nx;
                            o_out.pixel_y <= w_ny;
                            o_out.intensity <= (r_nonempty && w_d < 512) ? w_prod[16:9]
                                                                         : 8'd0;
                            o_out.last_of_run <= (r_j == 2'd2 && r_k == 2'd2);
                            if (r_k == 2'd2) begin
                                r_k <= 2'd0;
                                r_j <= r_j + 2'd1;
                            end else r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_count <= N, "point count overflow")
    `ASSERT_NEVER(a_out_idle, i_clk, i_rst_n, o_out_valid && r_state != S_EMIT,
        "output valid outside emit")
    `ASSERT_CLK(a_last_end, i_clk, i_rst_n,
        (o_out_valid && o_out.last_of_run && !i_out_stall) |=> r_state == S_IDLE,
        "run did not end after last item")
endmodule
`default_nettype wire

@@ src/bdcs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bdcs_cell (
    input  wire logic                          i_clk,
    input  wire bdcs_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic [bdcs_pkg::CoordW-1:0]   i_load_x,
    input  wire logic [bdcs_pkg::CoordW-1:0]   i_load_y,
    input  wire logic [bdcs_pkg::CoordW-1:0]   i_next_x,
    input  wire logic [bdcs_pkg::CoordW-1:0]   i_next_y,
    output logic [bdcs_pkg::CoordW-1:0]        o_x,
    output logic [bdcs_pkg::CoordW-1:0]        o_y
);
    logic [bdcs_pkg::CoordW-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_ctrl.shift) begin
            r_x <= bdcs_pkg::lerp(r_x, i_next_x, i_ctrl.t);
            r_y <= bdcs_pkg::lerp(r_y, i_next_y, i_ctrl.t);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    localparam int NumRandom = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    bdcs_pkg::t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    bdcs_pkg::t_out_item o_out;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = bdcs_pkg::CFG_WIDTH;
    logic [10:0] i_cfg_data = '0;

    bezier_de_casteljau_splat_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    bdcs_pkg::t_in_item pending_items[$];
    bdcs_pkg::t_out_item expected_pixels[$];
    logic [17:0] curve_x[bdcs_pkg::MaxPoints];
    logic [17:0] curve_y[bdcs_pkg::MaxPoints];
    int stored_points = 0;
    int width_setting = 700;
    int height_setting = 700;
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_off = 0;
    int accepted_items = 0;
    int retired_items = 0;
    bit long_hold_due = 1'b0;

    function automatic logic [17:0] blend(logic [17:0] a, logic [17:0] b, int unsigned t);
        longint unsigned s;
        s = longint'(a) * (65536 - t) + longint'(b) * t + 32768;
        return s[33:16];
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int limit_frame(int size);
        if (size == 0) return 1;
        if (size > 1024) return 1024;
        return size;
    endfunction

    task automatic predict_request(bdcs_pkg::t_in_item item);
        logic [17:0] wx[bdcs_pkg::MaxPoints];
        logic [17:0] wy[bdcs_pkg::MaxPoints];
        int unsigned t;
        int px, py, wmax, hmax, bx, by, nx, ny, d, idx;
        int offs[3];
        bdcs_pkg::t_out_item r;
        offs = '{0, -1, 1};
        px = 0;
        py = 0;
        idx = 0;
        case (item.req_type)
            bdcs_pkg::REQ_CLEAR: stored_points = 0;
            bdcs_pkg::REQ_LOAD: begin
                if (stored_points < bdcs_pkg::MaxPoints) begin
                    curve_x[stored_points] = item.point_x;
                    curve_y[stored_points] = item.point_y;
                    stored_points++;
                end
            end
            bdcs_pkg::REQ_EVAL: begin
                t = item.t_value > 65536 ? 65536 : item.t_value;
                for (int i = 0; i < stored_points; i++) begin
                    wx[i] = curve_x[i];
                    wy[i] = curve_y[i];
                end
                for (int lv = stored_points - 1; lv > 0; lv--) begin
                    for (int i = 0; i < lv; i++) begin
                        wx[i] = blend(wx[i], wx[i+1], t);
                        wy[i] = blend(wy[i], wy[i+1], t);
                    end
                end
                if (stored_points > 0) begin
                    px = wx[0];
                    py = wy[0];
                end
                wmax = limit_frame(width_setting) - 1;
                hmax = limit_frame(height_setting) - 1;
                bx = clamp_to(px >> 8, wmax);
                by = clamp_to(py >> 8, hmax);
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        nx = clamp_to(bx + offs[j], wmax);
                        ny = clamp_to(by + offs[k], hmax);
                        d = (px > nx*256+128 ? px - (nx*256+128) : nx*256+128 - px)
                          + (py > ny*256+128 ? py - (ny*256+128) : ny*256+128 - py);
                        r.pixel_x = nx[9:0];
                        r.pixel_y = ny[9:0];
                        r.intensity = (stored_points > 0 && d < 512)
                                    ? 8'(((512 - d) * 255) / 512) : 8'd0;
                        r.last_of_run = (idx == 8);
                        expected_pixels.push_back(r);
                        idx++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || retired_items < accepted_items) begin
            if (retired_items < accepted_items) begin
                void'(pending_items.pop_front());
                retired_items++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in <= pending_items[0];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_request(i_in);
            accepted_items++;
        end
    end

    always @(negedge i_clk) begin
        if (long_hold_due) begin
            long_hold_due <= 1'b0;
            hold_off <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= ($urandom_range(0, 1) == 0);
        end else if ($urandom_range(0, 40) == 0) begin
            hold_off <= $urandom_range(5, 30);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        bdcs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected item %h", $time, o_out);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out !== want) begin
                    $display("%0t: expected x=%0d y=%0d i=%0d l=%0d, got x=%0d y=%0d i=%0d l=%0d",
                        $time, want.pixel_x, want.pixel_y, want.intensity, want.last_of_run,
                        o_out.pixel_x, o_out.pixel_y, o_out.intensity, o_out.last_of_run);
                    errors++;
                end
            end
        end
    end

    function automatic bdcs_pkg::t_in_item make_item(logic [1:0] kind, logic [17:0] x,
                                                     logic [17:0] y, logic [16:0] t);
        bdcs_pkg::t_in_item it;
        it.req_type = kind;
        it.point_x = x;
        it.point_y = y;
        it.t_value = t;
        return it;
    endfunction

    function automatic logic [16:0] random_t();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'h10000;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [17:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 18'd0;
            1: return 18'h3FFFF;
            default: return 18'($urandom_range(0, 262143));
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_frame(logic idx, logic [10:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bdcs_pkg::CFG_WIDTH) width_setting = value;
        else height_setting = value;
    endtask

    initial begin
        int n;
        logic [10:0] sizes[6];
        sizes = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd700, 11'd3};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h08000));
        pending_items.push_back(make_item(bdcs_pkg::REQ_LOAD, 18'h3FFFF, 18'h3FFFF, 17'd0));
        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h1FFFF));
        pending_items.push_back(make_item(bdcs_pkg::REQ_LOAD, 18'd0, 18'd0, 17'h1FFFF));
        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h00000));
        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h10000));
        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h08000));
        pending_items.push_back(make_item(2'd3, 18'h3FFFF, 18'h3FFFF, 17'h1FFFF));
        pending_items.push_back(make_item(bdcs_pkg::REQ_CLEAR, 18'h2AAAA, 18'h15555,
                                          17'h0AAAA));
        for (int i = 0; i < bdcs_pkg::MaxPoints + 2; i++)
            pending_items.push_back(make_item(bdcs_pkg::REQ_LOAD,
                                              18'(18'h00180 + i * 18'h1100),
                                              18'(18'h3FF80 - i * 18'h1000), 17'd0));
        pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, 18'd0, 18'd0, 17'h05555));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_frame(bdcs_pkg::CFG_WIDTH, sizes[phase]);
            write_frame(bdcs_pkg::CFG_HEIGHT, sizes[(phase + 3) % 6]);
            if (phase == 2) long_hold_due <= 1'b1;
            n = 0;
            while (n < NumRandom / 6) begin
                pending_items.push_back(make_item(bdcs_pkg::REQ_CLEAR, random_coord(),
                                                  random_coord(), random_t()));
                repeat ($urandom_range(1, 5))
                    pending_items.push_back(make_item(bdcs_pkg::REQ_LOAD, random_coord(),
                                                      random_coord(), random_t()));
                repeat ($urandom_range(1, 3))
                    pending_items.push_back(make_item(bdcs_pkg::REQ_EVAL, random_coord(),
                                                      random_coord(), random_t()));
                if ($urandom_range(0, 4) == 0)
                    pending_items.push_back(make_item(2'($urandom_range(0, 3)), random_coord(),
                                                      random_coord(), random_t()));
                n += 5;
            end
            drain();
        end

        if (errors == 0) begin
            $display("[bezier_de_casteljau_splat_top] OK");
        end else begin
            $display("[bezier_de_casteljau_splat_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[bezier_de_casteljau_splat_top] ERROR");
        $finish;
    end
endmodule
